### rtl/osr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osr_pkg
// Shared types and constants for the open-loop start-up ramp generator:
// payload structs, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package osr_pkg;

  localparam int ANGLE_BITS  = 32;
  localparam int DIV_CNT_W   = $clog2(ANGLE_BITS);
  localparam int PP_W        = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_REF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD = 3'd4;

  typedef struct packed {
    logic               kind;
    logic [31:0]        start_angle;
    logic signed [31:0] obs_speed;
    logic               est_converging;
  } in_t;

  typedef struct packed {
    logic               running;
    logic               stepped;
    logic [31:0]        elec_angle;
    logic [31:0]        mech_angle;
    logic signed [15:0] iq_cmd;
    logic               converged;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic angle;
    logic conv;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic step_ok;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

### rtl/openloop_startup_ramp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// openloop_startup_ramp
// Open-loop I/F start-up generator: ramps a virtual speed, advances the
// electrical angle and reports the mechanical angle until the estimator locks.
// ----------------------------------------------------------------------------
// One item is in work at a time. A start item, or a tick while idle or with
// zero pole pairs, runs the exec and finish steps only; a stepping tick adds
// the angle, convergence and divide steps. The mechanical angle comes from
// a restoring divider that yields one quotient bit per cycle. The result sits
// in an output register, so the next item is taken while it waits for the
// sink. Configuration writes land immediately and must be made while idle.
module openloop_startup_ramp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire osr_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output osr_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [osr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [osr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  osr_pkg::cmd_t cmd;
  osr_pkg::sts_t sts;

  osr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  osr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### rtl/osr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osr_div
// Restoring divider, one quotient bit per cycle: angle / pole pairs.
// ----------------------------------------------------------------------------
module osr_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [osr_pkg::ANGLE_BITS-1:0] dividend,
  input  wire logic [osr_pkg::PP_W-1:0]       divisor,
  output logic                                done,
  output logic [osr_pkg::ANGLE_BITS-1:0]      quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic [osr_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [osr_pkg::ANGLE_BITS-1:0] quo_r;
  logic [osr_pkg::PP_W-1:0]       rem_r;
  logic [osr_pkg::PP_W-1:0]       div_r;

  logic [osr_pkg::PP_W:0]         trial;
  logic                           ge;
  logic [osr_pkg::PP_W:0]         diff;

  always_comb begin
    trial = {rem_r, quo_r[osr_pkg::ANGLE_BITS-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= osr_pkg::DIV_CNT_W'(osr_pkg::ANGLE_BITS - 1);
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      quo_r <= {quo_r[osr_pkg::ANGLE_BITS-2:0], ge};
      // remainder stays below the divisor, so it fits PP_W bits
      rem_r <= ge ? diff[osr_pkg::PP_W-1:0] : trial[osr_pkg::PP_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

### rtl/osr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osr_dp
// Datapath: configuration registers, speed/angle state, convergence check,
// mechanical angle divider and the result register.
// ----------------------------------------------------------------------------
module osr_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [osr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [osr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire osr_pkg::in_t                     in_data,
  input  wire osr_pkg::cmd_t                    cmd,
  output osr_pkg::sts_t                         sts,
  output osr_pkg::out_t                         out_data
);

  // configuration
  logic [31:0]               ramp_r;
  logic [31:0]               target_r;
  logic [osr_pkg::PP_W-1:0]  pp_r;
  logic [15:0]               cur_ref_r;
  logic [31:0]               thr_r;

  // run state
  logic                           run_r;
  logic [31:0]                    speed_r;
  logic [osr_pkg::ANGLE_BITS-1:0] angle_r;

  // per-item working registers
  osr_pkg::in_t  in_r;
  logic [33:0]   diff_r;
  logic          stepped_r;
  logic          conv_r;
  osr_pkg::out_t out_r;

  logic [32:0]   sum;
  logic [31:0]   speed_nxt;
  logic [33:0]   err_mag;
  logic          err_lt;
  logic          step_ok;
  logic          div_done;
  logic [osr_pkg::ANGLE_BITS-1:0] quo;

  always_comb begin
    sum       = {1'b0, speed_r} + {1'b0, ramp_r};
    speed_nxt = (sum > {1'b0, target_r}) ? target_r : sum[31:0];
    err_mag   = diff_r[33] ? (34'd0 - diff_r) : diff_r;
    err_lt    = err_mag < {2'b00, thr_r};
    step_ok   = run_r && (pp_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r    <= '0;
      target_r  <= '0;
      pp_r      <= osr_pkg::PP_W'(1);
      cur_ref_r <= '0;
      thr_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        osr_pkg::REG_RAMP_STEP:       ramp_r    <= cfg_wdata;
        osr_pkg::REG_TARGET_SPEED:    target_r  <= cfg_wdata;
        osr_pkg::REG_POLE_PAIRS:      pp_r      <= cfg_wdata[osr_pkg::PP_W-1:0];
        osr_pkg::REG_CURRENT_REF:     cur_ref_r <= cfg_wdata[15:0];
        osr_pkg::REG_SPEED_THRESHOLD: thr_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      speed_r <= '0;
      angle_r <= '0;
    end else begin
      if (cmd.exec) begin
        if (in_r.kind) begin
          run_r   <= 1'b1;
          speed_r <= '0;
          angle_r <= in_r.start_angle[osr_pkg::ANGLE_BITS-1:0];
        end else if (step_ok) begin
          speed_r <= speed_nxt;
        end
      end
      if (cmd.angle) begin
        angle_r <= angle_r + speed_r[osr_pkg::ANGLE_BITS-1:0];
      end
      if (cmd.conv && in_r.est_converging && err_lt) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.exec) begin
      stepped_r <= !in_r.kind && step_ok;
      conv_r    <= 1'b0;
    end
    if (cmd.angle) begin
      // exact signed error, two bits of headroom
      diff_r <= {{2{in_r.obs_speed[31]}}, in_r.obs_speed} - {2'b00, speed_r};
    end
    if (cmd.conv) begin
      conv_r <= in_r.est_converging && err_lt;
    end
    if (cmd.load_out) begin
      out_r.running    <= run_r;
      out_r.stepped    <= stepped_r;
      out_r.elec_angle <= stepped_r ? 32'(angle_r) : 32'd0;
      out_r.mech_angle <= stepped_r ? 32'(quo) : 32'd0;
      out_r.iq_cmd     <= stepped_r ? cur_ref_r : 16'sd0;
      out_r.converged  <= conv_r;
    end
  end

  osr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.conv),
    .dividend (angle_r),
    .divisor  (pp_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    sts.is_start = in_r.kind;
    sts.step_ok  = step_ok;
    sts.div_done = div_done;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

### rtl/osr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osr_ctrl
// Controller: sequences one item through exec, then angle, convergence and
// divide for a stepping tick only, then finish; owns input ready, output valid.
// ----------------------------------------------------------------------------
module osr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire osr_pkg::sts_t sts,
  output osr_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ANGLE = 3'd2;
  localparam logic [2:0] S_CONV  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (sts.is_start || !sts.step_ok) ? S_FIN : S_ANGLE;
      end
      S_ANGLE: begin
        cmd.angle = 1'b1;
        state_nxt = S_CONV;
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/osr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osr_checker
// Port-level checks on the start-up ramp generator's result stream.
// ----------------------------------------------------------------------------
module osr_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire osr_pkg::out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a beat that did not step carries no angle, current or convergence
  a_no_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stepped |->
      out_data.elec_angle == 32'd0 && out_data.mech_angle == 32'd0 &&
      out_data.iq_cmd == 16'sd0 && !out_data.converged)
    else $error("non-stepping beat has nonzero fields");

  // convergence ends the run and only happens on a stepping tick
  a_conv_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.converged |-> out_data.stepped && !out_data.running)
    else $error("converged beat inconsistent with run state");

  // dividing by at least one never grows the angle
  a_mech_le_elec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stepped |-> out_data.mech_angle <= out_data.elec_angle)
    else $error("mechanical angle exceeds electrical angle");

endmodule

bind openloop_startup_ramp osr_checker u_osr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
